[src/ipra_pkg.sv]
`timescale 1ns / 1ps

package ipra_pkg;

    // Field and register widths
    localparam int SessionWidth = 16;
    localparam int SizeWidth    = 24;
    localparam int RetryWidth   = 8;
    localparam int SeqWidth     = 32;
    localparam int CountWidth   = 16;
    localparam int CrcWidth     = 32;
    localparam int CfgIdxWidth  = 2;

    // Register reset values
    localparam logic [SessionWidth-1:0] SessionReset   = 16'd1;
    localparam logic [SizeWidth-1:0]    FrameSizeReset = 24'd0;
    localparam logic [SizeWidth-1:0]    FrameLimReset  = 24'd119296;
    localparam logic [RetryWidth-1:0]   RetryReset     = 8'd5;

    localparam logic [CrcWidth-1:0] CrcInit = 32'hFFFF_FFFF;
    localparam logic [CrcWidth-1:0] CrcPoly = 32'hEDB8_8320;

    // Configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_SESSION    = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_FRAME_SIZE = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_FRAME_LIM  = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_RETRY      = 2'd3;

    // Event codes
    localparam logic [1:0] CMD_HEADER  = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] CMD_BYTE    = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // Packet kinds; every other code is treated as an unknown kind.
    localparam logic [2:0] KIND_DATA   = 3'd0;
    localparam logic [2:0] KIND_START  = 3'd1;
    localparam logic [2:0] KIND_COMMIT = 3'd2;
    localparam logic [2:0] KIND_DONE   = 3'd3;

    // Outcome codes
    localparam logic [1:0] OUT_RUNNING = 2'd0;
    localparam logic [1:0] OUT_SINGLE  = 2'd1;
    localparam logic [1:0] OUT_BATCH   = 2'd2;
    localparam logic [1:0] OUT_FAILED  = 2'd3;

    // Transfer phase, including how the transfer ended.
    typedef enum logic [7:0] {
        PH_WAIT        = 8'b0000_0001,
        PH_SINGLE      = 8'b0000_0010,
        PH_BATCH       = 8'b0000_0100,
        PH_DRAIN       = 8'b0000_1000,
        PH_END_SINGLE  = 8'b0001_0000,
        PH_END_BATCHOK = 8'b0010_0000,
        PH_END_NONE    = 8'b0100_0000,
        PH_END_BATCHNG = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]              cmd;
        logic                    header_good;
        logic [2:0]              packet_kind;
        logic [SessionWidth-1:0] packet_session;
        logic [SeqWidth-1:0]     packet_seq;
        logic                    last_flag;
        logic [CountWidth-1:0]   payload_count;
        logic                    store_accepted;
        logic [7:0]              payload_byte;
    } in_word_t;

    typedef struct packed {
        logic                ack_req;
        logic [SeqWidth-1:0] ack_number;
        logic                store_strobe;
        logic                batch_mode;
        logic                finished;
        logic [1:0]          outcome;
        logic [CrcWidth-1:0] payload_crc;
    } out_word_t;

    // Reflected CRC-32 update over one byte, bit by bit.
    function automatic logic [CrcWidth-1:0] crc_byte(
        input logic [CrcWidth-1:0] c,
        input logic [7:0]          b
    );
        logic [CrcWidth-1:0] r;
        r = c ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
        end
        return r;
    endfunction

endpackage

[src/inorder_packet_receiver_acker.sv]
`timescale 1ns / 1ps

// Receiver side of a sequenced transfer. Each input word is one event (packet
// header, receive timeout, payload byte or restart) and yields exactly one
// registered result word. A new word is accepted in every cycle unless the result
// register still holds a word that has not been taken; the whole update,
// including the byte-wide CRC-32 step, sits between the accepted input and the
// result register. Configuration is written through cfg_wr_en / cfg_index /
// cfg_data only while no event is in flight, a user rule the block does not
// enforce; a restart event clears the transfer state but keeps the configuration.
module inorder_packet_receiver_acker
    import ipra_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [SizeWidth-1:0]   cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_word_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_word_t              out_data
);

    // Configuration registers
    logic [SessionWidth-1:0] session_reg;
    logic [SizeWidth-1:0]    frame_size_reg;
    logic [SizeWidth-1:0]    frame_lim_reg;
    logic [RetryWidth-1:0]   retry_reg;

    // Transfer state
    phase_t                phase_reg, phase_next;
    logic [SeqWidth-1:0]   expected_reg, expected_next;
    logic [RetryWidth-1:0] timeout_reg, timeout_next;
    logic [RetryWidth-1:0] drain_reg, drain_next;
    logic [SizeWidth-1:0]  stored_reg, stored_next;
    logic [CountWidth-1:0] left_reg, left_next;
    logic                  storable_reg, storable_next;
    logic [SeqWidth-1:0]   last_seq_reg, last_seq_next;
    logic [CrcWidth-1:0]   crc_reg, crc_next;

    // Result register
    logic      out_valid_reg;
    out_word_t out_data_reg;
    out_word_t result;

    // Working signals
    logic                  accept;
    logic                  ended_before;
    logic                  ended_after;
    phase_t                phase_eff;
    logic                  ack;
    logic [SeqWidth-1:0]   ack_no;
    logic                  strobe;
    logic [RetryWidth-1:0] drain_inc;
    logic [RetryWidth-1:0] drain_step;
    logic [SizeWidth:0]    size_sum;
    logic                  size_bad;
    logic                  fits;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // End of transfer: single and drain end as single, batch by commit status.
    function automatic phase_t end_phase(input phase_t ph, input logic committed);
        phase_t r;
        unique case (ph)
            PH_SINGLE, PH_DRAIN: r = PH_END_SINGLE;
            PH_BATCH:            r = committed ? PH_END_BATCHOK : PH_END_BATCHNG;
            default:             r = PH_END_NONE;
        endcase
        return r;
    endfunction

    function automatic logic is_ended(input phase_t ph);
        return (ph == PH_END_SINGLE) || (ph == PH_END_BATCHOK) ||
               (ph == PH_END_NONE) || (ph == PH_END_BATCHNG);
    endfunction

    assign ended_before = is_ended(phase_reg);
    assign drain_inc    = drain_reg + 1'b1;
    assign size_sum     = {1'b0, stored_reg} + {{(SizeWidth+1-CountWidth){1'b0}},
                                                in_data.payload_count};
    assign fits         = size_sum <= {1'b0, frame_size_reg};
    assign size_bad     = (frame_size_reg == '0) || (frame_size_reg > frame_lim_reg);

    // Next state and result for the word at the input.
    always_comb
    begin
        phase_next    = phase_reg;
        expected_next = expected_reg;
        timeout_next  = timeout_reg;
        drain_next    = drain_reg;
        stored_next   = stored_reg;
        left_next     = left_reg;
        storable_next = storable_reg;
        last_seq_next = last_seq_reg;
        crc_next      = crc_reg;
        phase_eff     = phase_reg;
        ack           = 1'b0;
        ack_no        = '0;
        strobe        = 1'b0;
        drain_step    = drain_reg;

        if (in_data.cmd == CMD_RESTART)
        begin
            phase_next    = PH_WAIT;
            expected_next = '0;
            timeout_next  = '0;
            drain_next    = '0;
            stored_next   = '0;
            left_next     = '0;
            storable_next = 1'b0;
            last_seq_next = '0;
            crc_next      = CrcInit;
        end
        else if (in_data.cmd == CMD_BYTE)
        begin
            // Bytes of an accepted packet are taken even after the end.
            if (left_reg != '0)
            begin
                left_next = left_reg - 1'b1;
                crc_next  = crc_byte(crc_reg, in_data.payload_byte);
                strobe    = storable_reg;
            end
        end
        else if (ended_before)
        begin
            // Headers and timeouts after the end are ignored.
        end
        else if (in_data.cmd == CMD_TIMEOUT)
        begin
            if (phase_reg == PH_DRAIN)
            begin
                ack        = 1'b1;
                ack_no     = last_seq_reg;
                drain_next = drain_inc;
                if (drain_inc >= retry_reg)
                begin
                    phase_next = PH_END_SINGLE;
                end
            end
            else if ((timeout_reg < retry_reg) && (expected_reg != '0))
            begin
                timeout_next = timeout_reg + 1'b1;
                ack          = 1'b1;
                ack_no       = expected_reg - 1'b1;
            end
            else
            begin
                phase_next = end_phase(phase_reg, 1'b0);
            end
        end
        else if (phase_reg == PH_DRAIN)
        begin
            // Draining: re-ack data, count anything else but the done packet.
            if (in_data.header_good && (in_data.packet_kind == KIND_DONE))
            begin
                phase_next = PH_END_SINGLE;
            end
            else
            begin
                if (in_data.header_good && (in_data.packet_kind == KIND_DATA))
                begin
                    ack    = 1'b1;
                    ack_no = in_data.packet_seq;
                end
                else
                begin
                    drain_step = drain_inc;
                end
                drain_next = drain_step;
                if (drain_step >= retry_reg)
                begin
                    phase_next = PH_END_SINGLE;
                end
            end
        end
        else
        begin
            // Packet header while waiting or running.
            timeout_next = '0;
            if (!in_data.header_good)
            begin
                phase_next = end_phase(phase_reg, 1'b0);
            end
            else if ((phase_reg == PH_WAIT) && (in_data.packet_kind == KIND_START))
            begin
                ack    = 1'b1;
                ack_no = '0;
                if (in_data.store_accepted)
                begin
                    phase_next    = PH_BATCH;
                    expected_next = '0;
                end
                else
                begin
                    phase_next = PH_END_NONE;
                end
            end
            else if ((phase_reg == PH_WAIT) &&
                     ((in_data.packet_kind != KIND_DATA) || size_bad))
            begin
                phase_next = PH_END_NONE;
            end
            else
            begin
                phase_eff  = (phase_reg == PH_WAIT) ? PH_SINGLE : phase_reg;
                phase_next = phase_eff;
                if ((phase_eff == PH_BATCH) && (in_data.packet_kind == KIND_COMMIT))
                begin
                    ack        = 1'b1;
                    ack_no     = '0;
                    phase_next = end_phase(phase_eff, in_data.store_accepted);
                end
                else if (in_data.packet_kind != KIND_DATA)
                begin
                    phase_next = end_phase(phase_eff, 1'b0);
                end
                else if (in_data.packet_session != session_reg)
                begin
                    // Wrong session: ignored without an ack.
                end
                else if (in_data.packet_seq < expected_reg)
                begin
                    ack    = 1'b1;
                    ack_no = in_data.packet_seq;
                end
                else if (in_data.packet_seq > expected_reg)
                begin
                    if (expected_reg != '0)
                    begin
                        ack    = 1'b1;
                        ack_no = expected_reg - 1'b1;
                    end
                end
                else
                begin
                    // In-order packet: accept its payload and ack it.
                    left_next = in_data.payload_count;
                    if (phase_eff == PH_BATCH)
                    begin
                        storable_next = 1'b1;
                    end
                    else
                    begin
                        storable_next = fits;
                        if (fits)
                        begin
                            stored_next = size_sum[SizeWidth-1:0];
                        end
                    end
                    expected_next = expected_reg + 1'b1;
                    ack           = 1'b1;
                    ack_no        = in_data.packet_seq;
                    if ((phase_eff == PH_SINGLE) && in_data.last_flag)
                    begin
                        phase_next    = (retry_reg == '0) ? PH_END_SINGLE : PH_DRAIN;
                        last_seq_next = in_data.packet_seq;
                        drain_next    = '0;
                    end
                end
            end
        end
    end

    // Result word built from the updated state.
    assign ended_after = is_ended(phase_next);

    always_comb
    begin
        result.ack_req      = ack;
        result.ack_number   = ack_no;
        result.store_strobe = strobe;
        result.batch_mode   = (phase_next == PH_BATCH) || (phase_next == PH_END_BATCHOK) ||
                              (phase_next == PH_END_BATCHNG);
        result.finished     = !ended_before && ended_after;
        result.payload_crc  = ~crc_next;
        unique case (phase_next)
            PH_END_SINGLE:  result.outcome = (stored_next != '0) ? OUT_SINGLE : OUT_FAILED;
            PH_END_BATCHOK: result.outcome = OUT_BATCH;
            PH_END_NONE,
            PH_END_BATCHNG: result.outcome = OUT_FAILED;
            default:        result.outcome = OUT_RUNNING;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg    <= SessionReset;
            frame_size_reg <= FrameSizeReset;
            frame_lim_reg  <= FrameLimReset;
            retry_reg      <= RetryReset;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SESSION:    session_reg    <= cfg_data[SessionWidth-1:0];
                CFG_FRAME_SIZE: frame_size_reg <= cfg_data;
                CFG_FRAME_LIM:  frame_lim_reg  <= cfg_data;
                CFG_RETRY:      retry_reg      <= cfg_data[RetryWidth-1:0];
                default:        ;
            endcase
        end
    end

    // Transfer state advances on every accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_WAIT;
            expected_reg <= '0;
            timeout_reg  <= '0;
            drain_reg    <= '0;
            stored_reg   <= '0;
            left_reg     <= '0;
            storable_reg <= 1'b0;
            last_seq_reg <= '0;
            crc_reg      <= CrcInit;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            expected_reg <= expected_next;
            timeout_reg  <= timeout_next;
            drain_reg    <= drain_next;
            stored_reg   <= stored_next;
            left_reg     <= left_next;
            storable_reg <= storable_next;
            last_seq_reg <= last_seq_next;
            crc_reg      <= crc_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

endmodule
